// ===== design/rrc_pkg.sv =====
// ----------------------------------------------------------------------------
// rrc_pkg
// Shared types and constants for the rational reduce and compare unit.
// ----------------------------------------------------------------------------
package rrc_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned MagWidth   = ValueWidth - 1;
  localparam int unsigned StepWidth  = $clog2(ValueWidth + 1);

  typedef struct packed {
    logic signed [31:0] first_num;
    logic signed [31:0] first_den;
    logic signed [31:0] second_num;
    logic signed [31:0] second_den;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] first_num_reduced;
    logic        [30:0] first_den_reduced;
    logic signed [31:0] second_num_reduced;
    logic        [30:0] second_den_reduced;
    logic               first_less;
    logic               equal;
    logic               bad_denominator;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV_NUM,
    ST_DIV_DEN,
    ST_NEXT,
    ST_MUL,
    ST_CMP,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic gcd_step;
    logic div_init_num;
    logic div_init_den;
    logic div_step;
    logic store_num;
    logic store_den;
    logic sel_second;
    logic mul;
    logic cmp;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic gcd_done;
    logic div_done;
  } stat_t;

endpackage

// ===== design/rrc_datapath.sv =====
// ----------------------------------------------------------------------------
// rrc_datapath
// Sign handling, Euclid gcd via restoring remainder, division and compare.
// ----------------------------------------------------------------------------
module rrc_datapath (
  input  logic               clk,
  input  logic               rst,
  input  rrc_pkg::in_item_t  in_item,
  input  rrc_pkg::ctrl_t     ctrl,
  output rrc_pkg::stat_t     stat,
  output rrc_pkg::out_item_t out_item
);

  localparam int unsigned W = rrc_pkg::MagWidth;
  localparam int unsigned S = rrc_pkg::StepWidth;

  logic [W-1:0] mag_n [2];
  logic [W-1:0] mag_d [2];
  logic         neg   [2];
  logic         bad   [2];

  // gcd: a, b with shift-subtract remainder of a mod b
  logic [W-1:0] ga, gb;
  logic [W-1:0] rem, quo, dvd, dvs;
  logic [S-1:0] cnt;
  logic         mod_phase;
  logic [W-1:0] red_n [2];
  logic [W-1:0] red_d [2];
  logic signed [63:0] prod_a, prod_b;

  logic [W-1:0] sel_n, sel_d;
  logic [W:0]   trial;
  logic [W-1:0] rem_shift;

  function automatic logic [W-1:0] abs_sat(input logic signed [31:0] v);
    logic [31:0] a;
    a = v[31] ? (~v + 32'd1) : v;
    if (a[31]) a = 32'h7FFF_FFFF;
    return a[W-1:0];
  endfunction

  always_comb begin
    sel_n     = ctrl.sel_second ? mag_n[1] : mag_n[0];
    sel_d     = ctrl.sel_second ? mag_d[1] : mag_d[0];
    rem_shift = {rem[W-2:0], dvd[W-1]};
    trial     = {rem[W-1], rem_shift} - {1'b0, dvs};
  end

  assign stat.gcd_done = (gb == '0) && !mod_phase;
  assign stat.div_done = (cnt == S'(W));

  // high while a remainder a mod b is being worked out
  always_ff @(posedge clk) begin
    if (rst) begin
      mod_phase <= 1'b0;
    end else if (ctrl.load || ctrl.store_den) begin
      mod_phase <= 1'b0;
    end else if (ctrl.gcd_step && (!mod_phase || cnt == S'(W))) begin
      mod_phase <= !mod_phase;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      bad[0]   <= (in_item.first_den == '0);
      bad[1]   <= (in_item.second_den == '0);
      mag_n[0] <= (in_item.first_den == '0) ? '0 : abs_sat(in_item.first_num);
      mag_d[0] <= (in_item.first_den == '0) ? W'(1) : abs_sat(in_item.first_den);
      mag_n[1] <= (in_item.second_den == '0) ? '0 : abs_sat(in_item.second_num);
      mag_d[1] <= (in_item.second_den == '0) ? W'(1) : abs_sat(in_item.second_den);
      neg[0]   <= (in_item.first_den != '0) && (in_item.first_num != '0)
                  && (in_item.first_num[31] ^ in_item.first_den[31]);
      neg[1]   <= (in_item.second_den != '0) && (in_item.second_num != '0)
                  && (in_item.second_num[31] ^ in_item.second_den[31]);
    end
    if (ctrl.gcd_step) begin
      if (!mod_phase) begin
        // start a mod a by b
        dvd <= ga; dvs <= gb; rem <= '0; cnt <= '0;
      end else if (cnt != S'(W)) begin
        dvd <= {dvd[W-2:0], 1'b0};
        rem <= trial[W] ? rem_shift : trial[W-1:0];
        cnt <= cnt + S'(1);
      end else begin
        ga <= gb; gb <= rem;
      end
    end
    if (ctrl.div_init_num || ctrl.div_init_den) begin
      dvd <= ctrl.div_init_num ? sel_n : sel_d;
      dvs <= ga; rem <= '0; quo <= '0; cnt <= '0;
    end
    if (ctrl.div_step) begin
      dvd <= {dvd[W-2:0], 1'b0};
      rem <= trial[W] ? rem_shift : trial[W-1:0];
      quo <= {quo[W-2:0], ~trial[W]};
      cnt <= cnt + S'(1);
    end
    if (ctrl.store_num) red_n[ctrl.sel_second] <= quo;
    if (ctrl.store_den) red_d[ctrl.sel_second] <= quo;
    if (ctrl.load || ctrl.store_den) begin
      // prime gcd for the next fraction (first on load)
      ga <= ctrl.load ? abs_sat(in_item.first_den == '0 ? 32'sd1 : in_item.first_den)
                      : mag_d[1];
      gb <= ctrl.load ? ((in_item.first_den == '0) ? '0 : abs_sat(in_item.first_num))
                      : mag_n[1];
    end
    if (ctrl.mul) begin
      prod_a <= $signed({1'b0, red_n[0]}) * $signed({1'b0, red_d[1]});
      prod_b <= $signed({1'b0, red_n[1]}) * $signed({1'b0, red_d[0]});
    end
    if (ctrl.cmp) begin
      out_item.first_num_reduced  <= neg[0] ? -$signed({1'b0, red_n[0]})
                                            : $signed({1'b0, red_n[0]});
      out_item.first_den_reduced  <= red_d[0];
      out_item.second_num_reduced <= neg[1] ? -$signed({1'b0, red_n[1]})
                                            : $signed({1'b0, red_n[1]});
      out_item.second_den_reduced <= red_d[1];
      unique case ({neg[0], neg[1]})
        2'b00: out_item.first_less <= prod_a < prod_b;
        2'b11: out_item.first_less <= prod_b < prod_a;
        2'b10: out_item.first_less <= 1'b1;
        default: out_item.first_less <= 1'b0;
      endcase
      out_item.equal <= (neg[0] == neg[1]) && (red_n[0] == red_n[1])
                        && (red_d[0] == red_d[1]);
      out_item.bad_denominator <= bad[0] | bad[1];
    end
  end

  // gcd of a fraction with nonzero denominator is never zero during division
  assert property (@(posedge clk) disable iff (rst) ctrl.div_step |-> dvs != '0)
    else $error("division by zero gcd");
  assert property (@(posedge clk) disable iff (rst)
    ctrl.cmp |=> out_item.first_den_reduced != '0)
    else $error("reduced denominator zero");
  assert property (@(posedge clk) disable iff (rst)
    ctrl.cmp |=> !(out_item.equal && out_item.first_less))
    else $error("equal and less together");

endmodule

// ===== design/rrc_controller.sv =====
// ----------------------------------------------------------------------------
// rrc_controller
// Sequences gcd, two divisions per fraction, multiply and compare.
// ----------------------------------------------------------------------------
module rrc_controller (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  rrc_pkg::stat_t stat,
  output rrc_pkg::ctrl_t ctrl,
  output logic           busy,
  output logic           done
);

  rrc_pkg::state_t state, state_next;
  logic second, second_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= rrc_pkg::ST_IDLE;
      second <= 1'b0;
    end else begin
      state  <= state_next;
      second <= second_next;
    end
  end

  always_comb begin
    state_next      = state;
    second_next     = second;
    ctrl            = '0;
    ctrl.sel_second = second;
    busy            = (state != rrc_pkg::ST_IDLE);
    done            = 1'b0;
    unique case (state)
      rrc_pkg::ST_IDLE: begin
        if (start) begin
          ctrl.load   = 1'b1;
          second_next = 1'b0;
          state_next  = rrc_pkg::ST_GCD;
        end
      end
      rrc_pkg::ST_GCD: begin
        if (stat.gcd_done) begin
          ctrl.div_init_num = 1'b1;
          state_next        = rrc_pkg::ST_DIV_NUM;
        end else begin
          ctrl.gcd_step = 1'b1;
        end
      end
      rrc_pkg::ST_DIV_NUM: begin
        if (stat.div_done) begin
          ctrl.store_num    = 1'b1;
          ctrl.div_init_den = 1'b1;
          state_next        = rrc_pkg::ST_DIV_DEN;
        end else begin
          ctrl.div_step = 1'b1;
        end
      end
      rrc_pkg::ST_DIV_DEN: begin
        if (stat.div_done) begin
          ctrl.store_den = 1'b1;
          state_next     = rrc_pkg::ST_NEXT;
        end else begin
          ctrl.div_step = 1'b1;
        end
      end
      rrc_pkg::ST_NEXT: begin
        if (second) begin
          state_next = rrc_pkg::ST_MUL;
        end else begin
          second_next = 1'b1;
          state_next  = rrc_pkg::ST_GCD;
        end
      end
      rrc_pkg::ST_MUL: begin
        ctrl.mul   = 1'b1;
        state_next = rrc_pkg::ST_CMP;
      end
      rrc_pkg::ST_CMP: begin
        ctrl.cmp   = 1'b1;
        state_next = rrc_pkg::ST_DONE;
      end
      rrc_pkg::ST_DONE: begin
        done       = 1'b1;
        state_next = rrc_pkg::ST_IDLE;
      end
      default: state_next = rrc_pkg::ST_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("busy after done");
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("start not taken");

endmodule

// ===== design/rational_reduce_and_compare_unit.sv =====
// ----------------------------------------------------------------------------
// rational_reduce_and_compare_unit
// Reduces two signed fractions to lowest terms and compares them.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; the result
// appears on result with done, which is high for one cycle, and cannot be stalled.
// Each fraction runs a Euclid gcd (each remainder takes a start step, 31
// shift-subtract steps and a swap step, and a final step ends the gcd)
// followed by two 31-step divisions and one hand-over state. The single
// shared shift-subtract unit does every remainder and division step, so
// a new transaction is taken only once done has passed and the unit is
// back in idle. busy stays high throughout.
module rational_reduce_and_compare_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  rrc_pkg::in_item_t  operands,
  output logic               busy,
  output logic               done,
  output rrc_pkg::out_item_t result
);

  rrc_pkg::ctrl_t ctrl;
  rrc_pkg::stat_t stat;

  rrc_controller u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .ctrl (ctrl),
    .busy (busy),
    .done (done)
  );

  rrc_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .in_item (operands),
    .ctrl    (ctrl),
    .stat    (stat),
    .out_item(result)
  );

endmodule
